// ----- rtl/sorted_list_table_top_assert.svh -----
// Assertion macros shared by the sorted list table RTL.
// IMPL checks a consequent in the same cycle, NEXT checks it in the cycle after.
`ifndef SORTED_LIST_TABLE_TOP_ASSERT_SVH
`define SORTED_LIST_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SLT_AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list table: assertion failed");
`define SLT_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list table: assertion failed");
`else
`define SLT_AST_IMPL(lbl, clk, rst_n, ante, cons)
`define SLT_AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/slt_pkg.sv -----
`timescale 1ns / 1ps

package slt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int OUT_CNT_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                 success;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] probes;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 is_empty;
    } t_result;

endpackage

// ----- rtl/slt_ram.sv -----
`timescale 1ns / 1ps

module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/slt_walk.sv -----
`timescale 1ns / 1ps
`include "sorted_list_table_top_assert.svh"

module slt_walk #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [slt_pkg::CMD_W-1:0]        i_command,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    output logic                             o_fin,
    input  logic                             i_fin_ack,
    output slt_pkg::t_result                 o_res,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr,
    input  logic [slt_pkg::VALUE_W-1:0]      i_rd_data,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [slt_pkg::VALUE_W-1:0]      o_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUT,
        S_FIN
    } t_state;

    t_state                          r_state;
    slt_pkg::t_cmd                   r_cmd;
    logic signed [slt_pkg::VALUE_W-1:0] r_val;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_new_count;
    logic [CW-1:0]                   r_left;
    logic [CW-1:0]                   r_probes;
    logic [AW-1:0]                   r_ptr;
    logic [AW-1:0]                   r_didx;
    logic [AW-1:0]                   r_wpos;
    logic                            r_pend;
    logic                            r_shift;
    logic                            r_succ;
    logic                            r_full;

    logic                            w_issue;
    logic                            w_gt;
    logic                            w_lt;
    logic                            w_eq;
    logic                            w_last_up;
    logic                            w_first;

    assign w_issue   = (r_state == S_WALK) && (r_left != '0);
    assign w_gt      = $signed(i_rd_data) > r_val;
    assign w_lt      = $signed(i_rd_data) < r_val;
    assign w_eq      = $signed(i_rd_data) == r_val;
    assign w_last_up = (CW'(r_didx) + CW'(1)) == r_count;
    assign w_first   = r_didx == '0;

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_ptr;
    assign o_stall   = r_state != S_IDLE;
    assign o_fin     = r_state == S_FIN;

    assign o_res = '{
        success:     r_succ,
        table_full:  r_full,
        probes:      slt_pkg::OUT_CNT_W'(r_probes),
        entry_count: slt_pkg::OUT_CNT_W'(r_new_count),
        is_empty:    r_new_count == '0
    };

    // Insert shifts an entry up one place, remove shifts one down; reads run ahead
    // of the writes in the other direction, so no entry is read after being moved.
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_didx;
        o_wr_data = i_rd_data;
        if (r_state == S_WALK && r_pend) begin
            case (r_cmd)
                slt_pkg::CMD_INSERT: begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_didx + AW'(1);
                    o_wr_data = w_gt ? i_rd_data : $unsigned(r_val);
                end
                slt_pkg::CMD_REMOVE: begin
                    if (r_shift) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_didx - AW'(1);
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_PUT) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_wpos;
            o_wr_data = $unsigned(r_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_issue) begin
                r_didx <= r_ptr;
                r_left <= r_left - CW'(1);
                r_ptr  <= (r_cmd == slt_pkg::CMD_INSERT) ? r_ptr - AW'(1) : r_ptr + AW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= slt_pkg::t_cmd'(i_command);
                        r_val    <= i_value;
                        r_probes <= '0;
                        r_shift  <= 1'b0;
                        r_full   <= (slt_pkg::t_cmd'(i_command) == slt_pkg::CMD_INSERT)
                                    && (r_count >= CW'(CAPACITY));
                        case (slt_pkg::t_cmd'(i_command))
                            slt_pkg::CMD_INSERT: begin
                                if (r_count >= CW'(CAPACITY)) begin
                                    r_succ      <= 1'b0;
                                    r_new_count <= r_count;
                                    r_state     <= S_FIN;
                                end else if (r_count == '0) begin
                                    r_wpos      <= '0;
                                    r_new_count <= CW'(1);
                                    r_succ      <= 1'b1;
                                    r_state     <= S_PUT;
                                end else begin
                                    // walk down from the top entry
                                    r_ptr       <= AW'(r_count - CW'(1));
                                    r_left      <= r_count;
                                    r_new_count <= r_count + CW'(1);
                                    r_succ      <= 1'b1;
                                    r_state     <= S_WALK;
                                end
                            end
                            slt_pkg::CMD_SEARCH, slt_pkg::CMD_REMOVE: begin
                                r_succ      <= 1'b0;
                                r_new_count <= r_count;
                                if (r_count == '0) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_ptr   <= '0;
                                    r_left  <= r_count;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                r_new_count <= '0;
                                r_succ      <= 1'b1;
                                r_state     <= S_FIN;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_pend) begin
                        case (r_cmd)
                            slt_pkg::CMD_INSERT: begin
                                if (!w_gt) begin
                                    r_state <= S_FIN;
                                end else if (w_first) begin
                                    // every entry moved up: the new value goes to the head
                                    r_wpos  <= '0;
                                    r_state <= S_PUT;
                                end
                            end
                            slt_pkg::CMD_SEARCH: begin
                                r_probes <= CW'(r_didx) + CW'(1);
                                if (w_eq) begin
                                    r_succ  <= 1'b1;
                                    r_state <= S_FIN;
                                end else if (w_gt || w_last_up) begin
                                    r_state <= S_FIN;
                                end
                            end
                            slt_pkg::CMD_REMOVE: begin
                                if (r_shift || w_lt) begin
                                    if (w_last_up) begin
                                        r_state <= S_FIN;
                                    end
                                end else if (w_eq) begin
                                    r_shift     <= 1'b1;
                                    r_succ      <= 1'b1;
                                    r_new_count <= r_count - CW'(1);
                                    if (w_last_up) begin
                                        r_state <= S_FIN;
                                    end
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_PUT: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_fin_ack) begin
                        r_count <= r_new_count;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SLT_AST_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SLT_AST_IMPL(a_wr_state, i_clk, i_rst_n, o_wr_en, (r_state == S_WALK || r_state == S_PUT))
    `SLT_AST_NEXT(a_accept_busy, i_clk, i_rst_n, (i_valid && r_state == S_IDLE), r_state != S_IDLE)
    `SLT_AST_NEXT(a_fin_idle, i_clk, i_rst_n, (r_state == S_FIN && i_fin_ack), r_state == S_IDLE)

endmodule

// ----- rtl/sorted_list_table_top.sv -----
`timescale 1ns / 1ps
// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending order.
// Input channel: i_valid / o_stall with i_command (insert, search, remove, clear)
// and i_value. A transaction is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_success, o_table_full, o_probes,
// o_entry_count and o_is_empty; exactly one result transaction per command.
// The entries sit in one synchronous RAM (one write port, one read port, registered read).
// Search, remove and insert stream through the stored entries one per cycle:
// search and remove walk upwards from the lowest entry, insert walks down from the
// highest while shifting entries up. One command is worked on at a time; o_stall is
// high until it is done.
// A finished result waits in the output register while the next command is taken;
// if the receiver keeps i_stall high, the following command holds before completion.
// Reset (synchronous, active low) empties the table and drops any pending result.

module sorted_list_table_top #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [slt_pkg::CMD_W-1:0]          i_command,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_success,
    output logic                               o_table_full,
    output logic [slt_pkg::OUT_CNT_W-1:0]      o_probes,
    output logic [slt_pkg::OUT_CNT_W-1:0]      o_entry_count,
    output logic                               o_is_empty
);

    localparam int AW = $clog2(CAPACITY);

    logic                          w_fin;
    logic                          w_fin_ack;
    slt_pkg::t_result              w_res;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic [slt_pkg::VALUE_W-1:0]   w_rd_data;
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic [slt_pkg::VALUE_W-1:0]   w_wr_data;

    logic                          r_o_valid;
    slt_pkg::t_result              r_res;

    slt_ram #(
        .WIDTH (slt_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    slt_walk #(
        .CAPACITY (CAPACITY)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_value   (i_value),
        .o_fin     (w_fin),
        .i_fin_ack (w_fin_ack),
        .o_res     (w_res),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    // load the output register once it is free or being emptied this cycle
    assign w_fin_ack = w_fin && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fin_ack) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_ack) begin
            r_res <= w_res;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_success     = r_res.success;
    assign o_table_full  = r_res.table_full;
    assign o_probes      = r_res.probes;
    assign o_entry_count = r_res.entry_count;
    assign o_is_empty    = r_res.is_empty;

endmodule

// ----- verif/sorted_list_table_checker.sv -----
`timescale 1ns / 1ps

module sorted_list_table_checker #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  logic                               i_cmd_stall,
    input  logic [slt_pkg::CMD_W-1:0]          i_command,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_res_valid,
    input  logic                               i_res_stall,
    input  logic                               i_success,
    input  logic                               i_table_full,
    input  logic [slt_pkg::OUT_CNT_W-1:0]      i_probes,
    input  logic [slt_pkg::OUT_CNT_W-1:0]      i_entry_count,
    input  logic                               i_is_empty,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    logic signed [slt_pkg::VALUE_W-1:0] table_vals [CAPACITY];
    int                                 table_len = 0;
    slt_pkg::t_result                   awaited_results [$];

    // Apply one command to the shadow table and return the result it should give.
    function automatic slt_pkg::t_result apply_command(
        input slt_pkg::t_cmd cmd,
        input logic signed [slt_pkg::VALUE_W-1:0] val);
        slt_pkg::t_result res;
        int      pos;
        int      idx;
        int      walked;
        res    = '0;
        pos    = 0;
        walked = 0;
        case (cmd)
            slt_pkg::CMD_INSERT: begin
                if (table_len >= CAPACITY) begin
                    res.table_full = 1'b1;
                end else begin
                    // land after any equal values
                    while (pos < table_len && table_vals[pos] <= val) pos++;
                    for (idx = table_len; idx > pos; idx--) table_vals[idx] = table_vals[idx - 1];
                    table_vals[pos] = val;
                    table_len++;
                    res.success = 1'b1;
                end
            end
            slt_pkg::CMD_SEARCH: begin
                for (idx = 0; idx < table_len; idx++) begin
                    walked++;
                    if (table_vals[idx] == val) begin
                        res.success = 1'b1;
                        break;
                    end
                    if (table_vals[idx] > val) break;
                end
            end
            slt_pkg::CMD_REMOVE: begin
                while (pos < table_len && table_vals[pos] < val) pos++;
                if (pos < table_len && table_vals[pos] == val) begin
                    for (idx = pos; idx + 1 < table_len; idx++) table_vals[idx] = table_vals[idx + 1];
                    table_len--;
                    res.success = 1'b1;
                end
            end
            default: begin
                table_len   = 0;
                res.success = 1'b1;
            end
        endcase
        res.probes      = walked[slt_pkg::OUT_CNT_W-1:0];
        res.entry_count = table_len[slt_pkg::OUT_CNT_W-1:0];
        res.is_empty    = (table_len == 0);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        slt_pkg::t_result want;
        if (i_rst_n) begin
            // compare first: a result can never belong to the command taken at this edge
            if (i_res_valid && !i_res_stall) begin
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, %s%0b %s%0b %s%0d %s%0d %s%0b",
                             $time, "got success=", i_success, "full=", i_table_full,
                             "probes=", i_probes, "count=", i_entry_count,
                             "empty=", i_is_empty);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("success", int'(want.success), int'(i_success));
                    check_field("table_full", int'(want.table_full), int'(i_table_full));
                    check_field("probes", int'(want.probes), int'(i_probes));
                    check_field("entry_count", int'(want.entry_count), int'(i_entry_count));
                    check_field("is_empty", int'(want.is_empty), int'(i_is_empty));
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                awaited_results.push_back(apply_command(slt_pkg::t_cmd'(i_command), i_value));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- verif/sorted_list_table_top_test.sv -----
`timescale 1ns / 1ps

module sorted_list_table_top_test;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int SEGMENT_ITEMS = 120;
    localparam int POOL_SIZE     = 16;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DRAIN_CYCLES  = slt_pkg::CAPACITY_DEF + 8;

    localparam logic signed [slt_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [slt_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    logic                               i_clk     = 1'b0;
    logic                               i_rst_n   = 1'b0;
    logic                               i_valid   = 1'b0;
    logic [slt_pkg::CMD_W-1:0]          i_command = slt_pkg::CMD_INSERT;
    logic signed [slt_pkg::VALUE_W-1:0] i_value   = '0;
    logic                               i_stall   = 1'b0;
    logic                               o_stall;
    logic                               o_valid;
    logic                               o_success;
    logic                               o_table_full;
    logic [slt_pkg::OUT_CNT_W-1:0]      o_probes;
    logic [slt_pkg::OUT_CNT_W-1:0]      o_entry_count;
    logic                               o_is_empty;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int hold_off_reqs = 0;
    bit gaps_on       = 1'b1;

    logic signed [slt_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    sorted_list_table_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_probes      (o_probes),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    sorted_list_table_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_stall   (o_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_success     (o_success),
        .i_table_full  (o_table_full),
        .i_probes      (o_probes),
        .i_entry_count (o_entry_count),
        .i_is_empty    (o_is_empty),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [slt_pkg::VALUE_W-1:0] extreme_value();
        case ($urandom_range(3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // Mix of extremes, a tight cluster around zero and full-range values.
    function automatic void refresh_pool();
        int r;
        for (int k = 0; k < POOL_SIZE; k++) begin
            r = $urandom_range(9);
            if (r == 0)     value_pool[k] = extreme_value();
            else if (r < 4) value_pool[k] = int'($urandom_range(20)) - 10;
            else            value_pool[k] = $signed($urandom());
        end
    endfunction

    function automatic logic signed [slt_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 70)      return value_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 90) return $signed($urandom());
        else             return extreme_value();
    endfunction

    function automatic slt_pkg::t_cmd pick_command(input t_mix mix);
        int r;
        int ins_lim;
        int srch_lim;
        int rem_lim;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin ins_lim = 75; srch_lim = 90; rem_lim = 98; end
            MIX_DRAIN: begin ins_lim = 15; srch_lim = 35; rem_lim = 97; end
            default:   begin ins_lim = 35; srch_lim = 65; rem_lim = 95; end
        endcase
        if (r < ins_lim)       return slt_pkg::CMD_INSERT;
        else if (r < srch_lim) return slt_pkg::CMD_SEARCH;
        else if (r < rem_lim)  return slt_pkg::CMD_REMOVE;
        else                   return slt_pkg::CMD_CLEAR;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(99);
        if (r < 60)      return 0;
        else if (r < 92) return $urandom_range(3, 1);
        else             return $urandom_range(40, 8);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_command(input slt_pkg::t_cmd cmd,
                                 input logic signed [slt_pkg::VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int run_len;
        int holds_done;
        holds_done = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_reqs > holds_done) begin
                // long hold-off so the block fills up and stalls its input
                i_stall    <= 1'b1;
                run_len    = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end else if ($urandom_range(1) == 0) begin
                i_stall <= 1'b0;
                run_len = ($urandom_range(9) == 0) ? $urandom_range(200, 30)
                                                   : $urandom_range(20, 1);
            end else begin
                i_stall <= 1'b1;
                run_len = ($urandom_range(7) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3, 1);
            end
            repeat (run_len) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_mix mix;
        int   sent;
        int   seg;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        offer_command(slt_pkg::CMD_CLEAR, 32'sd0);          // clear of an empty table
        offer_command(slt_pkg::CMD_SEARCH, 32'sd5);         // search on an empty table
        offer_command(slt_pkg::CMD_REMOVE, 32'sd5);         // remove from an empty table
        offer_command(slt_pkg::CMD_INSERT, VALUE_MIN);
        offer_command(slt_pkg::CMD_INSERT, 32'sd0);
        offer_command(slt_pkg::CMD_INSERT, 32'sd0);         // duplicate lands after its twin
        offer_command(slt_pkg::CMD_SEARCH, 32'sd100);       // search past all entries
        offer_command(slt_pkg::CMD_INSERT, VALUE_MAX);
        offer_command(slt_pkg::CMD_INSERT, -32'sd1);
        offer_command(slt_pkg::CMD_SEARCH, -32'sd1);
        offer_command(slt_pkg::CMD_SEARCH, 32'sd1);         // stops at a greater entry
        offer_command(slt_pkg::CMD_SEARCH, VALUE_MAX);
        offer_command(slt_pkg::CMD_SEARCH, VALUE_MIN);
        offer_command(slt_pkg::CMD_REMOVE, 32'sd0);
        offer_command(slt_pkg::CMD_SEARCH, 32'sd0);
        offer_command(slt_pkg::CMD_REMOVE, 32'sd7);         // absent value
        offer_command(slt_pkg::CMD_REMOVE, VALUE_MIN);
        offer_command(slt_pkg::CMD_REMOVE, VALUE_MAX);
        offer_command(slt_pkg::CMD_CLEAR, 32'sh5a5a_5a5a);  // clear ignores the value
        offer_command(slt_pkg::CMD_SEARCH, 32'sd0);

        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg == 0) begin
                // fill to capacity back to back, then run into refused inserts
                mix     = MIX_FILL;
                gaps_on = 1'b0;
            end else begin
                mix     = t_mix'($urandom_range(2));
                gaps_on = ($urandom_range(3) != 0);
            end
            refresh_pool();
            for (int k = 0; k < SEGMENT_ITEMS && sent < RANDOM_ITEMS; k++) begin
                if (seg == 0 && k == 10) hold_off_reqs++;
                offer_command(pick_command(mix), pick_value());
                sent++;
            end
            seg++;
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
